/* hw/rtl/bpa_pkg.sv */
// Package with the types, constants and codes of the bitmap page allocator.
package bpa_pkg;

	localparam int MAX_PAGES = 1024;
	localparam int WORD_BITS = 32;
	localparam int WORD_SH   = $clog2(WORD_BITS);
	localparam int MAP_WORDS = MAX_PAGES / WORD_BITS + 1;
	localparam int WADDR_W   = $clog2(MAP_WORDS);
	localparam int PAGE_W    = 10;
	localparam int COUNT_W   = 11;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC = 2'd0,
		K_FREE  = 2'd1,
		K_INIT  = 2'd2,
		K_NOP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		S_OK       = 2'd0,
		S_NONE     = 2'd1,
		S_RANGE    = 2'd2,
		S_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL    = 1'b0,
		CFG_RESERVED = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_CHK,
		ST_INIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PAGE_W-1:0] page;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   granted_page;
		logic [COUNT_W-1:0]  free_count;
	} rsp_t;

endpackage

/* hw/rtl/bitmap_page_allocator.sv */
// Top level of the bitmap page allocator: control sequencer around the bitmap memory.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  kind, page
//   rsp      out        rsp_valid / rsp_stall  status, granted_page, free_count
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// During an allocate one bitmap word is read and checked per cycle.
// An allocate with a total of zero pages goes straight to the response without a scan.
// An initialize writes all 33 map words, one per cycle.
// A free checks its map word before the response; an out of range free or a no-op goes straight to it.
// After reset the map reads as all free through per-word valid bits.
// A stalled response is held in the output register while the next request is taken.
module bitmap_page_allocator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  bpa_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output bpa_pkg::rsp_t                      rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpa_pkg::COUNT_W-1:0]        cfg_data
);

	import bpa_pkg::*;

	function automatic logic [WORD_SH-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [WORD_SH-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = WORD_SH'(i);
			end
		end
		return idx;
	endfunction

	state_t                state_q, state_d;
	logic [COUNT_W-1:0]    total_q, rsvd_q, count_q, count_d;
	logic [COUNT_W-1:0]    eff_tot, eff_rsvd;
	logic [PAGE_W-1:0]     page_q, page_d, granted_q, granted_d;
	status_t               status_q, status_d;
	logic [WADDR_W-1:0]    init_w_q, init_w_d;
	logic [MAP_WORDS-1:0]  vld_q;
	logic                  vld_s1;
	logic [WADDR_W-1:0]    raddr, raddr_s1, waddr;
	logic                  we;
	logic [WORD_BITS-1:0]  wdata, rdata, word_eff, init_pat;
	logic [WORD_SH-1:0]    zbit;
	logic                  found;
	logic [PAGE_W-1:0]     idx;
	logic [COUNT_W-1:0]    next_base, init_base, init_diff;
	logic                  accept, rsp_load;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign eff_tot  = (total_q > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : total_q;
	assign eff_rsvd = (rsvd_q > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : rsvd_q;

	assign word_eff  = vld_s1 ? rdata : '0;
	assign found     = ~&word_eff;
	assign zbit      = lowest_zero(word_eff);
	assign idx       = {raddr_s1[PAGE_W-WORD_SH-1:0], zbit};
	assign next_base = (COUNT_W'(raddr_s1) + COUNT_W'(1)) << WORD_SH;

	assign init_base = COUNT_W'(init_w_q) << WORD_SH;
	assign init_diff = eff_rsvd - init_base;
	always_comb begin
		if (eff_rsvd >= init_base + COUNT_W'(WORD_BITS)) begin
			init_pat = '1;
		end else if (eff_rsvd > init_base) begin
			init_pat = ~({WORD_BITS{1'b1}} << init_diff[WORD_SH-1:0]);
		end else begin
			init_pat = '0;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		status_d  = status_q;
		granted_d = granted_q;
		init_w_d  = init_w_q;
		page_d    = page_q;
		we        = 1'b0;
		waddr     = raddr_s1;
		wdata     = word_eff;
		raddr     = raddr_s1 + WADDR_W'(1);
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = (req.kind == K_FREE) ? WADDR_W'(req.page >> WORD_SH) : '0;
				if (accept) begin
					page_d    = req.page;
					granted_d = '0;
					status_d  = S_OK;
					unique case (req.kind)
						K_ALLOC: begin
							if (eff_tot == '0) begin
								status_d = S_NONE;
								state_d  = ST_DONE;
							end else begin
								state_d = ST_SCAN;
							end
						end
						K_FREE: begin
							if (COUNT_W'(req.page) >= eff_tot) begin
								status_d = S_RANGE;
								state_d  = ST_DONE;
							end else begin
								state_d = ST_FREE_CHK;
							end
						end
						K_INIT: begin
							init_w_d = '0;
							count_d  = (rsvd_q >= eff_tot) ? '0 : eff_tot - rsvd_q;
							state_d  = ST_INIT;
						end
						K_NOP: begin
							state_d = ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_DONE;
					if (COUNT_W'(idx) >= eff_tot) begin
						status_d = S_NONE;
					end else begin
						we        = 1'b1;
						wdata     = word_eff | (WORD_BITS'(1) << zbit);
						granted_d = idx;
						count_d   = (count_q == '0) ? '0 : count_q - COUNT_W'(1);
					end
				end else if (next_base >= eff_tot) begin
					status_d = S_NONE;
					state_d  = ST_DONE;
				end
			end
			ST_FREE_CHK: begin
				state_d = ST_DONE;
				if (!word_eff[page_q[WORD_SH-1:0]]) begin
					status_d = S_NOT_USED;
				end else begin
					we      = 1'b1;
					wdata   = word_eff & ~(WORD_BITS'(1) << page_q[WORD_SH-1:0]);
					count_d = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
				end
			end
			ST_INIT: begin
				we    = 1'b1;
				waddr = init_w_q;
				wdata = init_pat;
				if (init_w_q == WADDR_W'(MAP_WORDS - 1)) begin
					state_d = ST_DONE;
				end else begin
					init_w_d = init_w_q + WADDR_W'(1);
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= COUNT_W'(MAX_PAGES);
			rsvd_q      <= '0;
			count_q     <= COUNT_W'(MAX_PAGES);
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TOTAL:    total_q <= cfg_data;
					CFG_RESERVED: rsvd_q  <= cfg_data;
					default:      total_q <= total_q;
				endcase
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		granted_q <= granted_d;
		init_w_q  <= init_w_d;
		page_q    <= page_d;
		raddr_s1  <= raddr;
		vld_s1    <= vld_q[raddr];
		if (rsp_load) begin
			rsp_q.status       <= status_q;
			rsp_q.granted_page <= granted_q;
			rsp_q.free_count   <= count_q;
		end
	end

endmodule

/* hw/rtl/bpa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
